[hw/rtl/chd_pkg.sv]
// Shared types, constants and code table of the camera DPCM Huffman decoder.
package chd_pkg;

    localparam int CFG_W = 11;
    localparam int SIZE_W = 13;
    localparam int BUF_W = 15;
    localparam int HELD_W = 4;
    localparam int CNT_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET = 11'd352;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 11'd288;

    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } chd_item_t;

    typedef struct packed {
        logic [HELD_W-1:0] len;
        logic signed [5:0] delta;
        logic              is_abs;
    } chd_code_t;

    function automatic chd_code_t decode_code(input logic [7:0] w);
        chd_code_t c;
        c.len = 4'd8;
        c.delta = 6'sd0;
        c.is_abs = 1'b0;
        if ((w & 8'h80) == 8'h00) begin
            c.len = 4'd1;
        end
        else if ((w & 8'hE0) == 8'h80) begin
            c.len = 4'd3;
            c.delta = 6'sd4;
        end
        else if ((w & 8'hE0) == 8'hA0) begin
            c.len = 4'd3;
            c.delta = -6'sd4;
        end
        else if ((w & 8'hF0) == 8'hD0) begin
            c.len = 4'd4;
            c.delta = 6'sd11;
        end
        else if ((w & 8'hF0) == 8'hF0) begin
            c.len = 4'd4;
            c.delta = -6'sd11;
        end
        else if ((w & 8'hF8) == 8'hC8) begin
            c.len = 4'd5;
            c.delta = 6'sd20;
        end
        else if ((w & 8'hFC) == 8'hC0) begin
            c.len = 4'd6;
            c.delta = -6'sd20;
        end
        else if ((w & 8'hFC) == 8'hC4) begin
            c.len = 4'd8;
        end
        else begin
            c.is_abs = 1'b1;
        end
        return c;
    endfunction

endpackage

[hw/rtl/chd_inq.sv]
// Input queue that takes compressed bytes and their frame-start flag.
module chd_inq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  chd_pkg::chd_item_t s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output chd_pkg::chd_item_t m_item
);
    import chd_pkg::*;

    chd_item_t           store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QPTR_W:0]     count_reg;
    logic [QPTR_W:0]     count_next;
    logic                push;
    logic                pop;

    assign s_ready = (count_reg != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign m_valid = (count_reg != '0);
    assign m_item = store_reg[rd_ptr_reg];
    assign push = s_valid && s_ready;
    assign pop = m_valid && m_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= s_item;
        end
    end

endmodule

[hw/rtl/chd_back.sv]
// Decoding engine: bit buffer, code decode, prediction, line store and output register.
module chd_back #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  chd_pkg::chd_item_t         in_item,
    input  logic [chd_pkg::SIZE_W-1:0] width_eff,
    input  logic [chd_pkg::SIZE_W-1:0] height_eff,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 out_pixel,
    output logic                       out_last_item,
    output logic                       out_frame_end
);
    import chd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = 2 * MAX_WIDTH;
    localparam int AW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [BUF_W-1:0]    buf_reg;
    logic [BUF_W-1:0]    buf_next;
    logic [HELD_W-1:0]   held_reg;
    logic [HELD_W-1:0]   held_next;
    logic [RW-1:0]       row_reg;
    logic [RW-1:0]       row_next;
    logic [CW-1:0]       col_reg;
    logic [CW-1:0]       col_next;
    logic                active_reg;
    logic                active_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [7:0]          left1_reg;
    logic [7:0]          left2_reg;
    logic [7:0]          top_reg;
    logic                out_valid_reg;
    logic [7:0]          out_pixel_reg;
    logic                out_last_reg;
    logic                out_end_reg;
    logic [7:0]          line_mem [DEPTH];

    logic [7:0]          window;
    chd_code_t           code;
    logic                row_low;
    logic                col_low;
    logic                raw;
    logic [HELD_W-1:0]   len;
    logic [8:0]          pair_sum;
    logic [7:0]          pred;
    logic signed [9:0]   sum;
    logic [7:0]          value;
    logic [HELD_W-1:0]   held_left;
    logic                row_done;
    logic                frame_done;
    logic                last_item;
    logic                emit;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;

    function automatic logic [AW-1:0] slot(input logic parity, input logic [CW-1:0] col);
        return parity ? AW'(MAX_WIDTH) + AW'(col) : AW'(col);
    endfunction

    assign in_ready = (state_reg == ST_LOAD);
    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last_item = out_last_reg;
    assign out_frame_end = out_end_reg;

    always_comb
    begin
        window = 8'(buf_reg >> (held_reg - 4'd8));
        code = decode_code(window);
        row_low = ((row_reg >> 1) == '0);
        col_low = ((col_reg >> 1) == '0);
        raw = row_low && col_low;
        len = raw ? 4'd8 : code.len;
        pair_sum = {1'b0, top_reg} + {1'b0, left2_reg};
        if (col_low)
        begin
            pred = top_reg;
        end
        else if (row_low)
        begin
            pred = left2_reg;
        end
        else
        begin
            pred = pair_sum[8:1];
        end
        sum = $signed({2'b00, pred}) + $signed({{4{code.delta[5]}}, code.delta});
        if (raw)
        begin
            value = window;
        end
        else if (code.is_abs)
        begin
            value = {window[3:0], 4'h0};
        end
        else if (sum < 10'sd0)
        begin
            value = 8'd0;
        end
        else if (sum > 10'sd255)
        begin
            value = 8'd255;
        end
        else
        begin
            value = sum[7:0];
        end
        held_left = held_reg - len;
        row_done = (SIZE_W'(col_reg) + 1'b1 >= width_eff);
        frame_done = row_done && (SIZE_W'(row_reg) + 1'b1 >= height_eff);
        last_item = frame_done || (held_left < 4'd8) || (cnt_reg == '1);
        emit = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        buf_next = buf_reg;
        held_next = held_reg;
        row_next = row_reg;
        col_next = col_reg;
        active_next = active_reg;
        cnt_next = cnt_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cnt_next = '0;
                    if (in_item.start)
                    begin
                        active_next = 1'b1;
                        buf_next = {7'b0, in_item.data};
                        held_next = 4'd8;
                        row_next = '0;
                        col_next = '0;
                        state_next = ST_EMIT;
                    end
                    else if (active_reg)
                    begin
                        buf_next = {buf_reg[6:0], in_item.data};
                        held_next = held_reg + 4'd8;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    buf_next = buf_reg & BUF_W'((16'd1 << held_left) - 16'd1);
                    held_next = held_left;
                    cnt_next = cnt_reg + 1'b1;
                    if (last_item)
                    begin
                        state_next = ST_LOAD;
                    end
                    if (frame_done)
                    begin
                        active_next = 1'b0;
                        buf_next = '0;
                        held_next = '0;
                        row_next = '0;
                        col_next = '0;
                    end
                    else if (row_done)
                    begin
                        row_next = row_reg + 1'b1;
                        col_next = '0;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign wr_addr = slot(row_reg[0], col_reg);
    assign rd_addr = slot(row_next[0], col_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            buf_reg <= '0;
            held_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            active_reg <= 1'b0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            buf_reg <= buf_next;
            held_reg <= held_next;
            row_reg <= row_next;
            col_reg <= col_next;
            active_reg <= active_next;
            cnt_reg <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_pixel_reg <= value;
            out_last_reg <= last_item;
            out_end_reg <= frame_done;
            left2_reg <= left1_reg;
            left1_reg <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            line_mem[wr_addr] <= value;
        end
        top_reg <= line_mem[rd_addr];
    end

endmodule

[hw/rtl/camera_dpcm_huffman_decoder_unit.sv]
// Top level of the camera DPCM Huffman decoder with its configuration registers.
// Compressed bytes enter a four-entry queue and are decoded one code per clock while the
// output is not stalled: each byte is first loaded into the bit buffer, then its codes
// are decoded in turn, since each code starts where the previous one ended. The line
// store is a memory of 2 * MAX_WIDTH pixels with one write and one registered read per
// cycle; it is never cleared. Pixels leave through an output register, so a stalled
// output holds back only the decoder while the queue still takes bytes. Configure the
// frame size only while the block is idle.
module camera_dpcm_huffman_decoder_unit #(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic                           s_axis_tuser,   // [0] frame_start
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [7:0]                     m_axis_tdata,   // [7:0] pixel
    output logic                           m_axis_tuser,   // [0] last_of_item
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [chd_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [chd_pkg::CFG_W-1:0]      cfg_data
);
    import chd_pkg::*;

    logic [CFG_W-1:0]  width_cfg_reg;
    logic [CFG_W-1:0]  height_cfg_reg;
    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;
    chd_item_t         in_item;
    chd_item_t         q_item;
    logic              q_valid;
    logic              q_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg <= FRAME_WIDTH_RESET;
            height_cfg_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_addr == REG_FRAME_WIDTH)
            begin
                width_cfg_reg <= cfg_data;
            end
            else if (cfg_addr == REG_FRAME_HEIGHT)
            begin
                height_cfg_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (width_cfg_reg < 11'd2)
        begin
            width_eff = SIZE_W'(2);
        end
        else if (SIZE_W'(width_cfg_reg) > SIZE_W'(MAX_WIDTH))
        begin
            width_eff = SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = SIZE_W'(width_cfg_reg);
        end
        if (height_cfg_reg < 11'd1)
        begin
            height_eff = SIZE_W'(1);
        end
        else if (SIZE_W'(height_cfg_reg) > SIZE_W'(MAX_HEIGHT))
        begin
            height_eff = SIZE_W'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = SIZE_W'(height_cfg_reg);
        end
    end

    assign in_item.start = s_axis_tuser;
    assign in_item.data = s_axis_tdata;

    chd_inq u_inq (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_item  (in_item),
        .m_valid (q_valid),
        .m_ready (q_ready),
        .m_item  (q_item)
    );

    chd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_item       (q_item),
        .width_eff     (width_eff),
        .height_eff    (height_eff),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_pixel     (m_axis_tdata),
        .out_last_item (m_axis_tuser),
        .out_frame_end (m_axis_tlast)
    );

endmodule

[hw/rtl/chd_checker.sv]
// Port-level assertions for the decoder top level and the bind that attaches them.
module chd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast
);

    // A stalled output transfer keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
    else $error("output changed while stalled");

    // The final pixel of a frame is also the last pixel of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("frame end without end of byte");

    // Pixels of one byte follow each other without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tuser |=> m_axis_tvalid)
    else $error("gap inside the pixels of one byte");

endmodule

bind camera_dpcm_huffman_decoder_unit chd_checker u_chd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
